// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_CLK(label, !(expr), msg)

`endif

// ----- src/bb3_pkg.sv -----
// Types and constants of the 3x3 box blur
package bb3_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef logic [11:0] sum_t;

    // neighbourhood size codes
    localparam logic [1:0] N_FOUR = 2'd0;
    localparam logic [1:0] N_SIX  = 2'd1;
    localparam logic [1:0] N_NINE = 2'd2;

    // position of an input pixel, as needed by the window stage
    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
        logic       r_ge1;
        logic       r_ge2;
        logic       c_ge1;
        logic       c_ge2;
        logic       last_col;
        logic       last_row;
    } pos_t;

    // one result before the division
    typedef struct packed {
        sum_t       sum_red;
        sum_t       sum_green;
        sum_t       sum_blue;
        logic [1:0] ncode;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } job_t;

endpackage

// ----- src/bb3_line_buf.sv -----
// Two line stores kept side by side in one memory, registered read
module bb3_line_buf
    import bb3_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [47:0]   rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [47:0]   wr_data
);

    logic [47:0] mem_reg [DEPTH];
    logic [47:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/bb3_window.sv -----
// 3x3 window and result sequencer: a sum per cycle while job_ready
module bb3_window
    import bb3_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load,
    input  pixel_t pix,
    input  pixel_t up1,
    input  pixel_t up2,
    input  pos_t   pos,
    output logic   load_ready,
    output logic   job_valid,
    output job_t   job,
    input  logic   job_ready
);

    pixel_t     win_reg [9];
    logic [3:0] pend_reg;
    logic [3:0] pend_next;
    pos_t       pos_reg;
    logic [1:0] sel;
    logic [3:0] sel_hot;
    logic       take;
    logic       ysel;
    logic       xsel;
    logic [2:0] row_ok;
    logic [2:0] col_ok;
    sum_t       sr;
    sum_t       sg;
    sum_t       sb;

    always_comb
    begin
        if (pend_reg[0])      sel = 2'd0;
        else if (pend_reg[1]) sel = 2'd1;
        else if (pend_reg[2]) sel = 2'd2;
        else                  sel = 2'd3;
    end

    assign sel_hot    = 4'b0001 << sel;
    assign job_valid  = |pend_reg;
    assign take       = job_valid && job_ready;
    assign load_ready = !job_valid || (take && ((pend_reg & ~sel_hot) == 4'd0));

    // results in order: (r-1,c-1) (r-1,c) (r,c-1) (r,c)
    assign ysel = sel[1];
    assign xsel = sel[0];

    assign row_ok = {1'b1, 1'b1, !ysel && pos_reg.r_ge2};
    assign col_ok = {1'b1, pos_reg.c_ge1, !xsel && pos_reg.c_ge2};

    always_comb
    begin
        sr = '0;
        sg = '0;
        sb = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (row_ok[i] && col_ok[j])
                begin
                    sr = sr + sum_t'(win_reg[i*3+j].red);
                    sg = sg + sum_t'(win_reg[i*3+j].green);
                    sb = sb + sum_t'(win_reg[i*3+j].blue);
                end
            end
        end
    end

    always_comb
    begin
        job.sum_red   = sr;
        job.sum_green = sg;
        job.sum_blue  = sb;
        if (row_ok[0] && col_ok[0])      job.ncode = N_NINE;
        else if (row_ok[0] || col_ok[0]) job.ncode = N_SIX;
        else                             job.ncode = N_FOUR;
        job.row  = ysel ? pos_reg.row : pos_reg.row - 10'd1;
        job.col  = xsel ? pos_reg.col : pos_reg.col - 10'd1;
        job.last = (sel == 2'd3);
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (take)
        begin
            pend_next = pend_reg & ~sel_hot;
        end
        if (load)
        begin
            if (pos.r_ge1)
            begin
                pend_next = {pos.last_row && pos.last_col, pos.last_row && pos.c_ge1,
                             pos.last_col, pos.c_ge1};
            end
            else
            begin
                pend_next = 4'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 4'd0;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            pend_reg <= pend_next;
            if (load)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i*3]   <= win_reg[i*3+1];
                    win_reg[i*3+1] <= win_reg[i*3+2];
                end
                win_reg[2] <= up2;
                win_reg[5] <= up1;
                win_reg[8] <= pix;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pos_reg <= pos;
        end
    end

endmodule

// ----- src/bb3_divide.sv -----
// Sum register, rounded division by the neighbourhood size, output register
module bb3_divide
    import bb3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    input  job_t       job,
    output logic       job_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [9:0] out_row,
    output logic [9:0] out_col,
    output logic       frame_last
);

    // (2*sum + n) / (2*n) with reciprocal multiplies for 12 and 18
    function automatic logic [7:0] mean(input sum_t s, input logic [1:0] nc);
        logic [12:0] v;
        logic [10:0] x3;
        logic [11:0] x9;
        logic [20:0] p3;
        logic [23:0] p9;
        logic [7:0]  q;
        x3 = '0;
        x9 = '0;
        case (nc)
            N_SIX:   v = {s, 1'b0} + 13'd6;
            N_NINE:  v = {s, 1'b0} + 13'd9;
            default: v = {s, 1'b0} + 13'd4;
        endcase
        x3 = v[12:2];
        x9 = v[12:1];
        p3 = 21'(x3) * 21'd683;
        p9 = 24'(x9) * 24'd3641;
        case (nc)
            N_SIX:   q = p3[18:11];
            N_NINE:  q = p9[22:15];
            default: q = v[10:3];
        endcase
        return q;
    endfunction

    logic       c_valid_reg;
    job_t       c_job_reg;
    logic       c_adv;
    logic       out_valid_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [9:0] row_reg;
    logic [9:0] col_reg;
    logic       last_reg;

    assign c_adv     = c_valid_reg && (!out_valid_reg || out_ready);
    assign job_ready = !c_valid_reg || c_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_ready)
            begin
                c_valid_reg <= job_valid;
            end
            if (c_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
        begin
            c_job_reg <= job;
        end
        if (c_adv)
        begin
            red_reg   <= mean(c_job_reg.sum_red, c_job_reg.ncode);
            green_reg <= mean(c_job_reg.sum_green, c_job_reg.ncode);
            blue_reg  <= mean(c_job_reg.sum_blue, c_job_reg.ncode);
            row_reg   <= c_job_reg.row;
            col_reg   <= c_job_reg.col;
            last_reg  <= c_job_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_red    = red_reg;
    assign out_green  = green_reg;
    assign out_blue   = blue_reg;
    assign out_row    = row_reg;
    assign out_col    = col_reg;
    assign frame_last = last_reg;

endmodule

// ----- src/box_blur_3x3_edge_aware.sv -----
// Top level of the edge-aware 3x3 box blur
//
// Pixels enter in raster order on the in_valid/in_ready channel, one request
// per pixel. Each result request on out_valid/out_ready carries the rounded
// per-channel mean of the in-frame 3x3 neighbourhood (4, 6 or 9 pixels) and
// the row and column of the blurred pixel; frame_last marks the bottom-right
// pixel. A result appears once its last neighbour has arrived: a pixel in a
// middle column gives one result, a last-column or last-row pixel two, the
// final pixel four, and pixels of row 0 or column 0 give none.
// Pipeline: input register with line store read, window, sum register,
// output register. One pixel is taken per cycle while nothing stalls; the
// window sequencer emits one result per cycle while the sum register takes
// it, so a pixel that releases more than one result holds the input until
// the window hands on its last result. When the receiver stalls the output
// register holds and back-pressure reaches in_ready through the pipeline;
// in_ready drops only when the window cannot take the pixel held in the
// input register. Reset clears position counters, window and valid flags
// and sets both sizes to their maximum; line stores need no clearing.
// Config: cfg_we writes cfg_data to width (index 0) or height (index 1);
// write only while the pipeline is empty.
module box_blur_3x3_edge_aware
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_red,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_blue,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [9:0]  out_row,
    output logic [9:0]  out_col,
    output logic        frame_last
);

    `include "assert_macros.svh"

    localparam int PW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    logic [10:0]   width_reg;
    logic [10:0]   height_reg;
    logic [CW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    logic [PW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [PW-1:0] col_cur;
    logic [RW-1:0] row_cur;
    logic [PW-1:0] col_next;
    logic [RW-1:0] row_next;
    logic          wrap_pos;
    logic          last_col;
    logic          last_row;
    logic          accept;

    // input stage
    logic          a_valid_reg;
    pixel_t        a_pix_reg;
    logic [PW-1:0] a_col_reg;
    pos_t          a_pos_reg;
    pos_t          pos_cur;
    logic          load;
    logic          load_ready;
    logic [47:0]   rd_data;

    logic          job_valid;
    logic          job_ready;
    job_t          job;

    // effective frame size, clamped to [2, max]
    always_comb
    begin
        if (width_reg < 11'd2)                  w_eff = CW'(2);
        else if (32'(width_reg) > MAX_WIDTH)    w_eff = CW'(MAX_WIDTH);
        else                                    w_eff = CW'(width_reg);
        if (height_reg < 11'd2)                 h_eff = HW'(2);
        else if (32'(height_reg) > MAX_HEIGHT)  h_eff = HW'(MAX_HEIGHT);
        else                                    h_eff = HW'(height_reg);
    end

    // a position left outside a shrunken frame restarts at the origin
    assign wrap_pos = (CW'(col_reg) >= w_eff) || (HW'(row_reg) >= h_eff);
    assign col_cur  = wrap_pos ? '0 : col_reg;
    assign row_cur  = wrap_pos ? '0 : row_reg;
    assign last_col = (CW'(col_cur) == w_eff - CW'(1));
    assign last_row = (HW'(row_cur) == h_eff - HW'(1));

    always_comb
    begin
        col_next = col_cur + PW'(1);
        row_next = row_cur;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_cur + RW'(1);
        end
    end

    always_comb
    begin
        pos_cur.row      = 10'(row_cur);
        pos_cur.col      = 10'(col_cur);
        pos_cur.r_ge1    = (row_cur != '0);
        pos_cur.r_ge2    = (RW'(row_cur) > RW'(1));
        pos_cur.c_ge1    = (col_cur != '0);
        pos_cur.c_ge2    = (PW'(col_cur) > PW'(1));
        pos_cur.last_col = last_col;
        pos_cur.last_row = last_row;
    end

    assign in_ready = !a_valid_reg || load_ready;
    assign accept   = in_valid && in_ready;
    assign load     = a_valid_reg && load_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= 11'(MAX_WIDTH);
            height_reg  <= 11'(MAX_HEIGHT);
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg  <= cfg_data;
                    CFG_HEIGHT: height_reg <= cfg_data;
                    default:    width_reg  <= width_reg;
                endcase
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_pix_reg <= '{red: in_red, green: in_green, blue: in_blue};
            a_col_reg <= col_cur;
            a_pos_reg <= pos_cur;
        end
    end

    // entry holds {two rows up, one row up}; written when the pixel moves on
    bb3_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (PW)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .rd_data (rd_data),
        .wr_en   (load),
        .wr_addr (a_col_reg),
        .wr_data ({rd_data[23:0], a_pix_reg})
    );

    bb3_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .pix        (a_pix_reg),
        .up1        (rd_data[23:0]),
        .up2        (rd_data[47:24]),
        .pos        (a_pos_reg),
        .load_ready (load_ready),
        .job_valid  (job_valid),
        .job        (job),
        .job_ready  (job_ready)
    );

    bb3_divide u_divide (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job        (job),
        .job_ready  (job_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_last (frame_last)
    );

    `ASSERT_CLK(a_last_col, out_valid && frame_last |-> out_col == 10'(w_eff - CW'(1)),
        "frame_last on a column other than the last")
    `ASSERT_CLK(a_last_row, out_valid && frame_last |-> out_row == 10'(h_eff - HW'(1)),
        "frame_last on a row other than the last")
    `ASSERT_NEVER(a_mem_hit, accept && load && (col_cur == a_col_reg),
        "line store read and write at the same column")

endmodule

// ----- tb/box_blur_3x3_edge_aware_tb.sv -----
// Self-checking testbench for the edge-aware 3x3 box blur
module box_blur_3x3_edge_aware_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bb3_pkg::*;

    // register indexes of the config port
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int LINE_MAX  = 1024;
    localparam int ROWS_MAX  = 1024;
    localparam int DRAIN_CYC = 12;   // pipeline is 4 deep; allow slack

    // pixel patterns for a frame
    typedef enum int {PAT_RANDOM, PAT_WHITE, PAT_BLACK, PAT_CHECKER} pattern_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } blur_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [10:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [9:0]  out_row;
    logic [9:0]  out_col;
    logic        frame_last;

    box_blur_3x3_edge_aware dut (.*);

    // Clock: 4 ns period
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // When set, neither side inserts idle cycles
    bit steady;
    int mismatches;

    // ------------------------------------------------------------------
    // Blur predictor: own copy of line stores, window, position and sizes
    // ------------------------------------------------------------------
    pixel_t      row_above2 [LINE_MAX];
    pixel_t      row_above1 [LINE_MAX];
    pixel_t      win [9];          // rows r-2..r, cols c-2..c, row-major
    int          pos_col;
    int          pos_row;
    logic [10:0] width_reg;
    logic [10:0] height_reg;

    blur_result_t expected_blur [$];

    function automatic int clamp_dim(logic [10:0] v, int hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    // Rounded mean around (y, x) using the window whose bottom-right is (r, c)
    function automatic blur_result_t neighborhood_mean(int y, int x, int r, int c,
                                                       int w, int h);
        blur_result_t res;
        int sr, sg, sb, n, ry, cx;
        sr = 0; sg = 0; sb = 0; n = 0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ry = r - 2 + i;
                cx = c - 2 + j;
                if (ry < 0 || cx < 0 || ry >= h || cx >= w) continue;
                if (ry - y > 1 || y - ry > 1 || cx - x > 1 || x - cx > 1) continue;
                sr += win[i*3+j].red;
                sg += win[i*3+j].green;
                sb += win[i*3+j].blue;
                n++;
            end
        end
        if (n == 0) n = 1;
        // round half up: n is added before the division
        res.red   = 8'((2*sr + n) / (2*n));
        res.green = 8'((2*sg + n) / (2*n));
        res.blue  = 8'((2*sb + n) / (2*n));
        res.row   = 10'(y);
        res.col   = 10'(x);
        res.last  = (y == h - 1 && x == w - 1);
        return res;
    endfunction

    task automatic predict_pixel(pixel_t pix);
        int w, h, c, r;
        pixel_t up2, up1;
        w = clamp_dim(width_reg, LINE_MAX);
        h = clamp_dim(height_reg, ROWS_MAX);
        if (pos_col >= w || pos_row >= h)
        begin
            pos_col = 0;
            pos_row = 0;
        end
        c = pos_col;
        r = pos_row;
        up2 = row_above2[c];
        up1 = row_above1[c];
        row_above2[c] = up1;
        row_above1[c] = pix;
        for (int i = 0; i < 3; i++)
        begin
            win[i*3]   = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = up2;
        win[5] = up1;
        win[8] = pix;
        // release order: above-left, above, then left and self on the last row
        if (r >= 1)
        begin
            if (c >= 1) expected_blur.push_back(neighborhood_mean(r-1, c-1, r, c, w, h));
            if (c == w - 1) expected_blur.push_back(neighborhood_mean(r-1, c, r, c, w, h));
            if (r == h - 1)
            begin
                if (c >= 1) expected_blur.push_back(neighborhood_mean(r, c-1, r, c, w, h));
                if (c == w - 1) expected_blur.push_back(neighborhood_mean(r, c, r, c, w, h));
            end
        end
        pos_col = c + 1;
        if (pos_col >= w)
        begin
            pos_col = 0;
            pos_row = (r + 1 >= h) ? 0 : r + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest one due
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n) out_ready <= 1'b0;
        else out_ready <= steady || ($urandom_range(99) >= 31);
    end

    always @(posedge clk)
    begin
        blur_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_blur.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result row %0d col %0d", out_row, out_col);
            end
            else
            begin
                exp_r = expected_blur.pop_front();
                if (out_red !== exp_r.red || out_green !== exp_r.green ||
                    out_blue !== exp_r.blue || out_row !== exp_r.row ||
                    out_col !== exp_r.col || frame_last !== exp_r.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: exp rgb %0d %0d %0d rc %0d %0d last %0d,",
                                 exp_r.red, exp_r.green, exp_r.blue, exp_r.row, exp_r.col,
                                 exp_r.last,
                                 " got %0d %0d %0d rc %0d %0d last %0d",
                                 out_red, out_green, out_blue, out_row, out_col,
                                 frame_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One pixel request; valid stays high into the next call unless a gap rolls
    task automatic send_pixel(pixel_t pix);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 31)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_red   = pix.red;
        in_green = pix.green;
        in_blue  = pix.blue;
        do @(posedge clk); while (!in_ready);
        predict_pixel(pix);
    endtask

    // Stop sending and wait until every result is in and the pipe is empty
    task automatic drain;
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_blur.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [10:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_WIDTH) width_reg = val;
        else height_reg = val;
    endtask

    task automatic set_size(logic [10:0] w, logic [10:0] h);
        drain();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // Send one whole frame at the current size
    task automatic send_frame(pattern_t pat, bit pause_midway);
        int w, h;
        pixel_t pix;
        w = clamp_dim(width_reg, LINE_MAX);
        h = clamp_dim(height_reg, ROWS_MAX);
        for (int r = 0; r < h; r++)
        begin
            for (int c = 0; c < w; c++)
            begin
                case (pat)
                    PAT_WHITE:   pix = 24'hFFFFFF;
                    PAT_BLACK:   pix = 24'h000000;
                    PAT_CHECKER: pix = ((r + c) % 2) ? 24'hFF00FF : 24'h00FF00;
                    default:     pix = 24'($urandom);
                endcase
                // sender holds off until every result so far has come out
                if (pause_midway && r == h / 2 && c == w / 2) drain();
                send_pixel(pix);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Smallest frames, flat extremes and a checkerboard for rounding
    task automatic test_extremes;
        set_size(11'd2, 11'd2);
        send_frame(PAT_WHITE, 1'b0);
        send_frame(PAT_BLACK, 1'b0);
        set_size(11'd3, 11'd3);
        send_frame(PAT_CHECKER, 1'b0);
    endtask

    // Sizes below 2 act as 2
    task automatic test_size_clamp;
        set_size(11'd0, 11'd1);
        send_frame(PAT_RANDOM, 1'b0);
        set_size(11'd1, 11'd0);
        send_frame(PAT_RANDOM, 1'b0);
    endtask

    // Random small frames, back-to-back at times, one paused mid-frame
    task automatic test_random_frames;
        int sent, frame_no;
        logic [10:0] w, h;
        sent = 0;
        frame_no = 0;
        while (sent < 470)
        begin
            if (frame_no == 0 || $urandom_range(3) != 0)
            begin
                w = ($urandom_range(9) == 0) ? 11'($urandom_range(1))
                                             : 11'($urandom_range(2, 12));
                h = ($urandom_range(9) == 0) ? 11'($urandom_range(1))
                                             : 11'($urandom_range(2, 12));
                set_size(w, h);
            end
            steady = (frame_no >= 5 && frame_no <= 8);
            send_frame(PAT_RANDOM, frame_no == 3);
            sent += clamp_dim(width_reg, LINE_MAX) * clamp_dim(height_reg, ROWS_MAX);
            frame_no++;
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_WIDTH;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_red     = '0;
        in_green   = '0;
        in_blue    = '0;
        steady     = 1'b0;
        mismatches = 0;
        pos_col    = 0;
        pos_row    = 0;
        width_reg  = 11'd1024;
        height_reg = 11'd1024;
        for (int i = 0; i < 9; i++) win[i] = '0;
        for (int i = 0; i < LINE_MAX; i++)
        begin
            row_above2[i] = '0;
            row_above1[i] = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_size_clamp();
        test_random_frames();

        drain();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/bb3_pkg.sv
src/bb3_line_buf.sv
src/bb3_window.sv
src/bb3_divide.sv
src/box_blur_3x3_edge_aware.sv
tb/box_blur_3x3_edge_aware_tb.sv
